// File: src/aes_block_cipher_rounds_macros.svh
// Assertion macros for the AES cipher rounds block.
`ifndef AES_BLOCK_CIPHER_ROUNDS_MACROS_SVH
`define AES_BLOCK_CIPHER_ROUNDS_MACROS_SVH
`ifndef SYNTHESIS
`define ABC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ABC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define ABC_ASSERT(label, clk, rst, prop, msg)
`define ABC_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif
`endif

// File: src/abc_pkg.sv
// ----------------------------------------------------------------------------
// abc_pkg
// Shared types, constants and round functions of the AES cipher rounds block.
// ----------------------------------------------------------------------------
package abc_pkg;
  localparam int KeySlots = 15;
  localparam int SlotW = 4;
  localparam int WordAddrW = 5;
  localparam logic [3:0] MinRounds = 4'd10;
  localparam logic [3:0] MaxRounds = 4'(KeySlots - 1);

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_ENC  = 2'd1,
    CMD_DEC  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef struct packed {
    logic          we;
    logic [SlotW-1:0] wslot;
    logic [127:0]  wdata;
    logic          re;
    logic [SlotW-1:0] rslot;
  } key_req_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] p, x;
    p = '0;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gmul = p;
  endfunction

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] ISBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };
endpackage

// File: src/abc_stream_if.sv
// ----------------------------------------------------------------------------
// abc_stream_if
// Valid/ready channel carrying a payload of a given type.
// ----------------------------------------------------------------------------
interface abc_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: src/abc_key_ram.sv
// ----------------------------------------------------------------------------
// abc_key_ram
// Round key store: one 128-bit row per slot, registered read.
// ----------------------------------------------------------------------------
module abc_key_ram (
  input  logic             clk,
  input  abc_pkg::key_req_t req,
  output logic [127:0]     rdata
);
  import abc_pkg::*;

  logic [127:0] mem [KeySlots];

  always_ff @(posedge clk) begin
    if (req.we && req.wslot < SlotW'(KeySlots)) begin
      mem[req.wslot] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.rslot];
    end
  end
endmodule

// File: src/abc_round.sv
// ----------------------------------------------------------------------------
// abc_round
// One AES round, forward or inverse, with first and last round variants.
// ----------------------------------------------------------------------------
module abc_round (
  input  logic [127:0] state_in,
  input  logic [127:0] round_key,
  input  logic         inverse,
  input  logic         key_only,
  input  logic         skip_mix,
  output logic [127:0] state_out
);
  import abc_pkg::*;

  logic [7:0] s [16];
  logic [7:0] sb [16];
  logic [7:0] sr [16];
  logic [7:0] ak [16];
  logic [7:0] mc [16];
  logic [7:0] k [16];
  logic [7:0] o [16];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_in[127-8*i -: 8];
      k[i] = round_key[127-8*i -: 8];
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        sr[r+4*c] = inverse ? s[r+4*((c-r+4)&3)] : s[r+4*((c+r)&3)];
      end
    end
    for (int i = 0; i < 16; i++) begin
      sb[i] = inverse ? ISBOX[sr[i]] : SBOX[sr[i]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inverse) begin
          ak[4*c+r] = sb[4*c+r] ^ k[4*c+r];
        end else begin
          ak[4*c+r] = sb[4*c+r];
        end
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inverse) begin
          mc[4*c+r] = gmul(ak[4*c+((r)&3)], 4'd14) ^ gmul(ak[4*c+((r+1)&3)], 4'd11)
                    ^ gmul(ak[4*c+((r+2)&3)], 4'd13) ^ gmul(ak[4*c+((r+3)&3)], 4'd9);
        end else begin
          mc[4*c+r] = gmul(ak[4*c+((r)&3)], 4'd2) ^ gmul(ak[4*c+((r+1)&3)], 4'd3)
                    ^ ak[4*c+((r+2)&3)] ^ ak[4*c+((r+3)&3)];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (key_only) begin
        o[i] = s[i] ^ k[i];
      end else if (inverse) begin
        o[i] = skip_mix ? ak[i] : mc[i];
      end else begin
        o[i] = (skip_mix ? ak[i] : mc[i]) ^ k[i];
      end
    end
    for (int i = 0; i < 16; i++) begin
      state_out[127-8*i -: 8] = o[i];
    end
  end
endmodule

// File: src/aes_block_cipher_rounds.sv
// ----------------------------------------------------------------------------
// aes_block_cipher_rounds
// AES cipher core with round keys held in an internal key memory.
// ----------------------------------------------------------------------------
// Usage: items arrive on the in_ch channel. A load transaction writes a
// 128-bit round key into a slot of the key memory and gives no result.
// An encrypt or decrypt transaction starts a run of Nr+1 rounds, one round
// per cycle, each round key being prefetched from the key memory through
// the single read port. Nr is num_rounds clamped to 10..14. The result is
// held in an output register on out_ch until the receiver takes it. While
// a result waits, the next load is still taken; a further cipher item is
// taken only once the receiver has taken the waiting result. Reset clears
// the control state and sets num_rounds to 10; the key memory is not
// cleared. A receiver stall holds the output register and keeps further
// cipher items from being accepted.
module aes_block_cipher_rounds (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  abc_stream_if.sink   in_ch,
  abc_stream_if.source out_ch
);
  import abc_pkg::*;
`include "aes_block_cipher_rounds_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  state_t       state;
  logic [3:0]   num_rounds;
  logic [3:0]   nr;
  logic [3:0]   round;
  logic         inverse;
  logic [127:0] blk;
  logic [127:0] blk_next;
  logic [127:0] rkey;
  logic [127:0] result;
  logic         out_valid;
  key_req_t     kreq;
  logic [3:0]   nr_eff;
  logic [3:0]   rd_idx;
  logic         accept;
  cmd_t         in_cmd;
  logic         is_first;
  logic         is_last;

  assign nr_eff = (num_rounds < MinRounds) ? MinRounds :
                  (num_rounds > MaxRounds) ? MaxRounds : num_rounds;
  assign in_cmd = cmd_t'(in_ch.payload.cmd);
  assign in_ch.ready = (state == ST_IDLE) && !(out_valid && in_cmd != CMD_LOAD);
  assign accept = in_ch.valid && in_ch.ready;

  // Round index r selects key r when encrypting and key Nr-r when decrypting.
  always_comb begin
    if (state == ST_IDLE) begin
      rd_idx = (in_cmd == CMD_DEC) ? nr_eff : 4'd0;
    end else begin
      rd_idx = inverse ? (nr - round - 4'd1) : (round + 4'd1);
    end
  end

  always_comb begin
    kreq.we    = accept && in_cmd == CMD_LOAD;
    kreq.wslot = in_ch.payload.key_slot;
    kreq.wdata = {in_ch.payload.data_hi, in_ch.payload.data_lo};
    kreq.re    = 1'b1;
    kreq.rslot = rd_idx;
  end

  abc_key_ram u_ram (.clk(clk), .req(kreq), .rdata(rkey));

  assign is_first = (round == 4'd0);
  assign is_last  = (round == nr);

  abc_round u_round (
    .state_in (blk),
    .round_key(rkey),
    .inverse  (inverse),
    .key_only (is_first),
    .skip_mix (is_last),
    .state_out(blk_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      num_rounds <= 4'd10;
      out_valid  <= 1'b0;
      round      <= '0;
      inverse    <= 1'b0;
      nr         <= 4'd10;
    end else begin
      if (cfg_we) num_rounds <= cfg_wdata;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept && (in_cmd == CMD_ENC || in_cmd == CMD_DEC)) begin
            state   <= ST_RUN;
            round   <= '0;
            inverse <= (in_cmd == CMD_DEC);
            nr      <= nr_eff;
            blk     <= {in_ch.payload.data_hi, in_ch.payload.data_lo};
          end
        end
        ST_RUN: begin
          blk   <= blk_next;
          round <= round + 4'd1;
          if (is_last) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          result    <= blk;
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.payload.result_hi = result[127:64];
  assign out_ch.payload.result_lo = result[63:0];

  `ABC_ASSERT(a_onehot, clk, rst, $onehot(state), "state not one-hot")
  `ABC_ASSERT(a_no_accept_run, clk, rst, !(state == ST_RUN && in_ch.ready), "ready while running")
  `ABC_ASSERT_NEXT(a_wait_out, clk, rst, state == ST_WAIT, out_valid, "result not posted")
  `ABC_ASSERT(a_round_bound, clk, rst, !(state == ST_RUN && round > nr), "round overrun")
endmodule
